### hw/rtl/bcss_pkg.sv
// Shared types, constants and helpers for the buck converter state-space step.
package bcss_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_W    = 24;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int ACC_W     = 48;
   localparam int CSR_IDX_W = 4;

   typedef logic signed [DATA_W-1:0] coef_type;

   // register map of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_A11 = 4'd0,
      REG_A12 = 4'd1,
      REG_A21 = 4'd2,
      REG_A22 = 4'd3,
      REG_B1  = 4'd4,
      REG_C11 = 4'd5,
      REG_C12 = 4'd6,
      REG_C22 = 4'd7
   } reg_index_type;

   typedef struct packed {
      coef_type a11;
      coef_type a12;
      coef_type a21;
      coef_type a22;
      coef_type b1;
      coef_type c11;
      coef_type c12;
      coef_type c22;
   } coef_set_type;

   localparam coef_type A11_RST = -32'sd7474;
   localparam coef_type A12_RST = -32'sd74527;
   localparam coef_type A21_RST = 32'sd7989;
   localparam coef_type A22_RST = -32'sd7989;
   localparam coef_type B1_RST  = 32'sd78252;
   localparam coef_type C11_RST = 32'sd798915;
   localparam coef_type C12_RST = 32'sd15978301;
   localparam coef_type C22_RST = 32'sd15978301;

   // current to load voltage gain, fixed at build time
   localparam coef_type OUT_COEF_21_DEF = 32'sd798915;

   typedef enum logic [1:0] {
      ACC_HOLD = 2'd0,
      ACC_INIT = 2'd1,
      ACC_LOAD = 2'd2,
      ACC_ADD  = 2'd3
   } acc_op_type;

   typedef struct packed {
      acc_op_type acc_op;
      logic       prod_en;
   } mac_ctrl_type;

   // clamp a wide accumulator value to the signed data range
   function automatic logic [DATA_W-1:0] sat_data(input logic [ACC_W-1:0] v);
      logic [ACC_W-DATA_W:0] top_bits;
      top_bits = v[ACC_W-1:DATA_W-1];
      if ((&top_bits) || !(|top_bits)) begin
         return v[DATA_W-1:0];
      end else if (v[ACC_W-1]) begin
         return {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         return {1'b0, {(DATA_W-1){1'b1}}};
      end
   endfunction

endpackage

### hw/rtl/bcss_csr.sv
// Coefficient register file written through the configuration port.
module bcss_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bcss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bcss_pkg::DATA_W-1:0]    csr_data,
   output bcss_pkg::coef_set_type         coefs
);

   bcss_pkg::coef_set_type coefs_ff;
   bcss_pkg::coef_set_type coefs_in;

   assign csr_ready = 1'b1;
   assign coefs     = coefs_ff;

   always_comb begin
      coefs_in = coefs_ff;
      if (csr_valid) begin
         case (bcss_pkg::reg_index_type'(csr_index))
            bcss_pkg::REG_A11: coefs_in.a11 = csr_data;
            bcss_pkg::REG_A12: coefs_in.a12 = csr_data;
            bcss_pkg::REG_A21: coefs_in.a21 = csr_data;
            bcss_pkg::REG_A22: coefs_in.a22 = csr_data;
            bcss_pkg::REG_B1:  coefs_in.b1  = csr_data;
            bcss_pkg::REG_C11: coefs_in.c11 = csr_data;
            bcss_pkg::REG_C12: coefs_in.c12 = csr_data;
            bcss_pkg::REG_C22: coefs_in.c22 = csr_data;
            default: ;  // unmapped index: write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff.a11 <= bcss_pkg::A11_RST;
         coefs_ff.a12 <= bcss_pkg::A12_RST;
         coefs_ff.a21 <= bcss_pkg::A21_RST;
         coefs_ff.a22 <= bcss_pkg::A22_RST;
         coefs_ff.b1  <= bcss_pkg::B1_RST;
         coefs_ff.c11 <= bcss_pkg::C11_RST;
         coefs_ff.c12 <= bcss_pkg::C12_RST;
         coefs_ff.c22 <= bcss_pkg::C22_RST;
      end else begin
         coefs_ff <= coefs_in;
      end
   end

endmodule

### hw/rtl/bcss_mac.sv
// Shared multiply-accumulate unit: registered 32x32 product, floor shift, wide accumulator.
module bcss_mac (
   input  logic                                clock,
   input  bcss_pkg::mac_ctrl_type              ctrl,
   input  bcss_pkg::coef_type                  mul_a,
   input  bcss_pkg::coef_type                  mul_b,
   input  logic signed [bcss_pkg::ACC_W-1:0]   base,
   output logic signed [bcss_pkg::ACC_W-1:0]   acc
);

   logic signed [bcss_pkg::PROD_W-1:0] prod_in;
   logic signed [bcss_pkg::PROD_W-1:0] prod_ff;
   logic signed [bcss_pkg::PROD_W-1:0] prod_shift;
   logic signed [bcss_pkg::ACC_W-1:0]  prod_q;
   logic signed [bcss_pkg::ACC_W-1:0]  acc_in;
   logic signed [bcss_pkg::ACC_W-1:0]  acc_ff;

   assign prod_in    = mul_a * mul_b;
   // arithmetic shift is floor division by 2^FRAC_W
   assign prod_shift = prod_ff >>> bcss_pkg::FRAC_W;
   assign prod_q     = prod_shift[bcss_pkg::ACC_W-1:0];
   assign acc        = acc_ff;

   always_comb begin
      case (ctrl.acc_op)
         bcss_pkg::ACC_HOLD: acc_in = acc_ff;
         bcss_pkg::ACC_INIT: acc_in = base;
         bcss_pkg::ACC_LOAD: acc_in = base + prod_q;
         bcss_pkg::ACC_ADD:  acc_in = acc_ff + prod_q;
         default:            acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.prod_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

endmodule

### hw/rtl/buck_converter_state_space_step.sv
// Top level: forward-Euler buck converter step sequenced over one shared MAC unit.
//
// Usage notes
// - req channel: one item per simulation time step, req_switch_on = 1 while the
//   power switch conducts. req_ready is high only while no step is in progress.
// - rsp channel: one item per request with the new inductor current and
//   capacitor voltage (the stored states) and the load current and voltage
//   from the output matrix, all signed Q8.24, saturated to 32 bits.
// - csr channel: always ready; index 0..7 selects a11 a12 a21 a22 b1 c11 c12
//   c22, other indexes are dropped. Write only while the block is idle.
// - Sequence: after the accept, states S0 to S9 issue the eight products
//   through the single 32x32 multiplier, with the multiplier idle in S5 and
//   S9 (S9 drains the last product into the accumulator), OUT loads the output
//   register, and the block returns to IDLE for the next accept. A new request
//   is not taken until the previous item has left OUT.
// - The result sits in an output register; if the receiver stalls, the next
//   item runs its arithmetic and then holds in its final cycle until the
//   output register frees up.
// - Reset (synchronous, active high): coefficients return to their defaults,
//   both states go to zero, no result pending.
module buck_converter_state_space_step #(
   parameter bcss_pkg::coef_type OUT_COEF_21 = bcss_pkg::OUT_COEF_21_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_switch_on,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [bcss_pkg::DATA_W-1:0] rsp_inductor_current,
   output logic signed [bcss_pkg::DATA_W-1:0] rsp_capacitor_voltage,
   output logic signed [bcss_pkg::DATA_W-1:0] rsp_load_current,
   output logic signed [bcss_pkg::DATA_W-1:0] rsp_load_voltage,
   // configuration channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bcss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bcss_pkg::DATA_W-1:0]    csr_data
);

   // one state per sequencer step; the schedule below names the product issued in each Sn
   typedef enum logic [11:0] {
      ST_IDLE = 12'h001,
      ST_S0   = 12'h002,
      ST_S1   = 12'h004,
      ST_S2   = 12'h008,
      ST_S3   = 12'h010,
      ST_S4   = 12'h020,
      ST_S5   = 12'h040,
      ST_S6   = 12'h080,
      ST_S7   = 12'h100,
      ST_S8   = 12'h200,
      ST_S9   = 12'h400,
      ST_OUT  = 12'h800
   } seq_state_type;

   localparam int ACC_W  = bcss_pkg::ACC_W;
   localparam int DATA_W = bcss_pkg::DATA_W;

   seq_state_type state_ff, state_in;
   logic          sw_ff, sw_in;

   logic signed [DATA_W-1:0] current_state_ff, current_state_in;
   logic signed [DATA_W-1:0] voltage_state_ff, voltage_state_in;
   logic signed [DATA_W-1:0] load_current_ff, load_current_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_ic_ff, rsp_ic_in;
   logic signed [DATA_W-1:0] rsp_vc_ff, rsp_vc_in;
   logic signed [DATA_W-1:0] rsp_il_ff, rsp_il_in;
   logic signed [DATA_W-1:0] rsp_vl_ff, rsp_vl_in;

   bcss_pkg::coef_set_type   coefs;
   bcss_pkg::mac_ctrl_type   mac_ctrl;
   bcss_pkg::coef_type       mul_a, mul_b;
   logic signed [ACC_W-1:0]  mac_base;
   logic signed [ACC_W-1:0]  mac_acc;
   logic signed [DATA_W-1:0] acc_sat;
   bcss_pkg::coef_type       b1_sel;

   logic req_accept;
   logic slot_free;
   logic finish;

   bcss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .coefs     (coefs)
   );

   bcss_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .base  (mac_base),
      .acc   (mac_acc)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign finish     = (state_ff == ST_OUT) && slot_free;
   assign acc_sat    = bcss_pkg::sat_data(mac_acc);
   assign b1_sel     = sw_ff ? coefs.b1 : '0;

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_inductor_current  = rsp_ic_ff;
   assign rsp_capacitor_voltage = rsp_vc_ff;
   assign rsp_load_current      = rsp_il_ff;
   assign rsp_load_voltage      = rsp_vl_ff;

   // sequencer
   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = req_accept ? ST_S0 : ST_IDLE;
         ST_S0:   state_in = ST_S1;
         ST_S1:   state_in = ST_S2;
         ST_S2:   state_in = ST_S3;
         ST_S3:   state_in = ST_S4;
         ST_S4:   state_in = ST_S5;
         ST_S5:   state_in = ST_S6;
         ST_S6:   state_in = ST_S7;
         ST_S7:   state_in = ST_S8;
         ST_S8:   state_in = ST_S9;
         ST_S9:   state_in = ST_OUT;
         ST_OUT:  state_in = slot_free ? ST_IDLE : ST_OUT;
         default: state_in = ST_IDLE;
      endcase
   end

   // Operand and accumulator schedule. Where the accumulator consumes a product,
   // it is the one issued in the previous state; S6 takes the S4 product held over S5.
   //   S0  i*a11            acc = i + b1 (switch on)
   //   S1  u*a12            acc += a11*i
   //   S2  i*a21            acc += a12*u          -> new current, wide
   //   S3  u*a22            acc = u + a21*i, current state updated
   //   S4  i_new*c11        acc += a22*u          -> new voltage, wide
   //   S5  idle             voltage state updated
   //   S6  u_new*c12        acc = c11*i_new
   //   S7  i_new*c21        acc += c12*u_new      -> load current, wide
   //   S8  u_new*c22        acc = c21*i_new, load current saved
   //   S9  idle             acc += c22*u_new      -> load voltage, wide
   //   OUT                  result registered when the output slot is free
   always_comb begin
      mul_a            = coefs.a11;
      mul_b            = current_state_ff;
      mac_base         = '0;
      mac_ctrl.acc_op  = bcss_pkg::ACC_HOLD;
      mac_ctrl.prod_en = 1'b0;
      case (state_ff)
         ST_S0: begin
            mul_a            = coefs.a11;
            mul_b            = current_state_ff;
            mac_base         = ACC_W'(current_state_ff) + ACC_W'(b1_sel);
            mac_ctrl.acc_op  = bcss_pkg::ACC_INIT;
            mac_ctrl.prod_en = 1'b1;
         end
         ST_S1: begin
            mul_a            = coefs.a12;
            mul_b            = voltage_state_ff;
            mac_ctrl.acc_op  = bcss_pkg::ACC_ADD;
            mac_ctrl.prod_en = 1'b1;
         end
         ST_S2: begin
            mul_a            = coefs.a21;
            mul_b            = current_state_ff;
            mac_ctrl.acc_op  = bcss_pkg::ACC_ADD;
            mac_ctrl.prod_en = 1'b1;
         end
         ST_S3: begin
            mul_a            = coefs.a22;
            mul_b            = voltage_state_ff;
            mac_base         = ACC_W'(voltage_state_ff);
            mac_ctrl.acc_op  = bcss_pkg::ACC_LOAD;
            mac_ctrl.prod_en = 1'b1;
         end
         ST_S4: begin
            mul_a            = coefs.c11;
            mul_b            = current_state_ff;
            mac_ctrl.acc_op  = bcss_pkg::ACC_ADD;
            mac_ctrl.prod_en = 1'b1;
         end
         ST_S6: begin
            mul_a            = coefs.c12;
            mul_b            = voltage_state_ff;
            mac_ctrl.acc_op  = bcss_pkg::ACC_LOAD;
            mac_ctrl.prod_en = 1'b1;
         end
         ST_S7: begin
            mul_a            = OUT_COEF_21;
            mul_b            = current_state_ff;
            mac_ctrl.acc_op  = bcss_pkg::ACC_ADD;
            mac_ctrl.prod_en = 1'b1;
         end
         ST_S8: begin
            mul_a            = coefs.c22;
            mul_b            = voltage_state_ff;
            mac_ctrl.acc_op  = bcss_pkg::ACC_LOAD;
            mac_ctrl.prod_en = 1'b1;
         end
         ST_S9: begin
            mac_ctrl.acc_op  = bcss_pkg::ACC_ADD;
         end
         default: ;
      endcase
   end

   // state, save and output registers
   always_comb begin
      sw_in            = req_accept ? req_switch_on : sw_ff;
      current_state_in = (state_ff == ST_S3) ? acc_sat : current_state_ff;
      voltage_state_in = (state_ff == ST_S5) ? acc_sat : voltage_state_ff;
      load_current_in  = (state_ff == ST_S8) ? acc_sat : load_current_ff;

      rsp_ic_in = rsp_ic_ff;
      rsp_vc_in = rsp_vc_ff;
      rsp_il_in = rsp_il_ff;
      rsp_vl_in = rsp_vl_ff;
      if (finish) begin
         rsp_ic_in    = current_state_ff;
         rsp_vc_in    = voltage_state_ff;
         rsp_il_in    = load_current_ff;
         rsp_vl_in    = acc_sat;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         current_state_ff <= '0;
         voltage_state_ff <= '0;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         current_state_ff <= current_state_in;
         voltage_state_ff <= voltage_state_in;
      end
   end

   always_ff @(posedge clock) begin
      sw_ff           <= sw_in;
      load_current_ff <= load_current_in;
      rsp_ic_ff       <= rsp_ic_in;
      rsp_vc_ff       <= rsp_vc_in;
      rsp_il_ff       <= rsp_il_in;
      rsp_vl_ff       <= rsp_vl_in;
   end

   // an accepted item always starts the schedule in the next cycle
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_S0))
      else $error("accepted item did not start the sequence");

   // a fresh result only appears out of the final sequencer cycle
   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the final cycle");

   // a stalled receiver keeps the finished item parked in the final cycle
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid && !rsp_ready) |=> (state_ff == ST_OUT))
      else $error("sequencer left the final cycle while output was blocked");

   // the model states are never updated out of the idle state
   a_state_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> $stable(current_state_ff) && $stable(voltage_state_ff))
      else $error("model state changed while idle");

endmodule
